FILE: hw/rtl/stxfr_pkg.sv
`timescale 1ns / 1ps

package stxfr_pkg;

    localparam int PAYLOAD_LEN = 16;
    localparam int IDX_W = (PAYLOAD_LEN > 1) ? $clog2(PAYLOAD_LEN) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PAYLOAD_LEN - 1);

    localparam int BYTE_W = 8;
    localparam int POS_W = 6;

    // input word kinds carried on s_axis_tuser
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TIMEOUT = 1'b1;

    // configuration register indexes
    localparam logic CFG_SYNC = 1'b0;
    localparam logic CFG_TYPE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_TIMEOUT = 2'd1,
        ST_BADTYPE = 2'd2,
        ST_BADSUM  = 2'd3
    } status_t;

    typedef struct packed {
        logic    store_byte;
        logic    seed_xor;
        logic    load_err;
        status_t err_code;
        logic    load_ok;
    } cmd_t;

    typedef struct packed {
        logic sync_hit;
        logic type_hit;
        logic sum_hit;
        logic rx_last;
        logic rd_last;
        logic out_free;
    } sts_t;

endpackage

FILE: hw/rtl/stxfr_datapath.sv
`timescale 1ns / 1ps

module stxfr_datapath
    import stxfr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [BYTE_W-1:0] cfg_data,
    input  logic [BYTE_W-1:0] link_byte,
    input  cmd_t              cmd,
    output sts_t              sts,
    input  logic              out_ready,
    output logic              out_valid,
    output status_t           out_status,
    output logic [BYTE_W-1:0] out_byte,
    output logic [POS_W-1:0]  out_index,
    output logic              out_last
);

    logic [BYTE_W-1:0] sync_value_reg;
    logic [BYTE_W-1:0] expected_type_reg;
    logic [BYTE_W-1:0] xor_reg;
    logic [BYTE_W-1:0] xor_next;
    logic [IDX_W-1:0]  rx_cnt_reg;
    logic [IDX_W-1:0]  rx_cnt_next;
    logic [IDX_W-1:0]  rd_cnt_reg;
    logic [IDX_W-1:0]  rd_cnt_next;
    logic [BYTE_W-1:0] store_reg [PAYLOAD_LEN];

    logic              out_valid_reg;
    logic              out_valid_next;
    status_t           out_status_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic [POS_W-1:0]  out_index_reg;
    logic              out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_value_reg    <= '0;
            expected_type_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SYNC: sync_value_reg <= cfg_data;
                CFG_TYPE: expected_type_reg <= cfg_data;
                default:  sync_value_reg <= sync_value_reg;
            endcase
        end
    end

    always_comb
    begin
        xor_next = xor_reg;
        rx_cnt_next = rx_cnt_reg;
        if (cmd.seed_xor)
        begin
            xor_next = link_byte;
            rx_cnt_next = '0;
        end
        else if (cmd.store_byte)
        begin
            xor_next = xor_reg ^ link_byte;
            rx_cnt_next = (rx_cnt_reg == LAST_IDX) ? '0 : rx_cnt_reg + 1'b1;
        end
    end

    always_comb
    begin
        rd_cnt_next = rd_cnt_reg;
        if (cmd.load_ok)
        begin
            rd_cnt_next = (rd_cnt_reg == LAST_IDX) ? '0 : rd_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xor_reg    <= '0;
            rx_cnt_reg <= '0;
            rd_cnt_reg <= '0;
        end
        else
        begin
            xor_reg    <= xor_next;
            rx_cnt_reg <= rx_cnt_next;
            rd_cnt_reg <= rd_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.store_byte)
        begin
            store_reg[rx_cnt_reg] <= link_byte;
        end
    end

    // output register: holds one result word until taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_err || cmd.load_ok)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_err)
        begin
            out_status_reg <= cmd.err_code;
            out_byte_reg   <= '0;
            out_index_reg  <= '0;
            out_last_reg   <= 1'b1;
        end
        else if (cmd.load_ok)
        begin
            out_status_reg <= ST_OK;
            out_byte_reg   <= store_reg[rd_cnt_reg];
            out_index_reg  <= POS_W'(rd_cnt_reg);
            out_last_reg   <= (rd_cnt_reg == LAST_IDX);
        end
    end

    assign sts.sync_hit = (link_byte == sync_value_reg);
    assign sts.type_hit = (link_byte == expected_type_reg);
    assign sts.sum_hit  = (link_byte == xor_reg);
    assign sts.rx_last  = (rx_cnt_reg == LAST_IDX);
    assign sts.rd_last  = (rd_cnt_reg == LAST_IDX);
    assign sts.out_free = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_byte   = out_byte_reg;
    assign out_index  = out_index_reg;
    assign out_last   = out_last_reg;

endmodule

FILE: hw/rtl/stxfr_ctrl.sv
`timescale 1ns / 1ps

module stxfr_ctrl
    import stxfr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  logic in_kind,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [4:0] {
        S_HUNT = 5'b00001,
        S_TYPE = 5'b00010,
        S_DATA = 5'b00100,
        S_CSUM = 5'b01000,
        S_EMIT = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign in_ready = (state_reg != S_EMIT) && sts.out_free;
    assign accept = in_valid && in_ready;

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.err_code = ST_OK;
        unique case (state_reg)
            S_EMIT:
            begin
                // drain the stored payload, one word per free output slot
                if (sts.out_free)
                begin
                    cmd.load_ok = 1'b1;
                    if (sts.rd_last)
                    begin
                        state_next = S_HUNT;
                    end
                end
            end
            default:
            begin
                if (accept)
                begin
                    if (in_kind == CMD_TIMEOUT)
                    begin
                        cmd.load_err = 1'b1;
                        cmd.err_code = ST_TIMEOUT;
                        state_next   = S_HUNT;
                    end
                    else
                    begin
                        unique case (state_reg)
                            S_HUNT:
                            begin
                                if (sts.sync_hit)
                                begin
                                    state_next = S_TYPE;
                                end
                            end
                            S_TYPE:
                            begin
                                if (sts.type_hit)
                                begin
                                    cmd.seed_xor = 1'b1;
                                    state_next   = S_DATA;
                                end
                                else
                                begin
                                    cmd.load_err = 1'b1;
                                    cmd.err_code = ST_BADTYPE;
                                    state_next   = S_HUNT;
                                end
                            end
                            S_DATA:
                            begin
                                cmd.store_byte = 1'b1;
                                if (sts.rx_last)
                                begin
                                    state_next = S_CSUM;
                                end
                            end
                            default:
                            begin
                                if (sts.sum_hit)
                                begin
                                    state_next = S_EMIT;
                                end
                                else
                                begin
                                    cmd.load_err = 1'b1;
                                    cmd.err_code = ST_BADSUM;
                                    state_next   = S_HUNT;
                                end
                            end
                        endcase
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_HUNT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTH
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("controller state not one-hot");

    a_no_input_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> !in_ready)
        else $error("input accepted during payload run");

    a_single_load: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.load_err && cmd.load_ok))
        else $error("error and payload loaded together");

    a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && sts.out_free && sts.rd_last) |=> (state_reg == S_HUNT))
        else $error("payload run did not end after last word");
`endif

endmodule

FILE: hw/rtl/sync_type_xor_frame_receiver.sv
`timescale 1ns / 1ps

// Framed packet receiver: sync byte, type byte, 16 payload bytes, XOR checksum.
// Input stream: one word per link byte (tuser = 0) or read timeout (tuser = 1).
// Output stream: on a good checksum, 16 payload words with index 0..15 and
// tlast on the final one; on a timeout, wrong type or bad checksum, one status
// word with tlast set. tuser carries the status code.
// Configuration: cfg_we writes the sync value (index 0) or expected type
// (index 1); write only while no frame is in flight.
// Timing: a result word is registered and appears the cycle after the input
// word that caused it; after the checksum word the controller enters its emit
// state and loads the payload run, one word per cycle while the output is taken.
// Throughput: one input word per cycle while hunting or receiving, if the
// output register is free; during a payload run the input is held off until
// all 16 stored bytes are loaded, one entry per cycle while the output is taken.
// A stalled output holds its word; the input is held off until the output
// register is free or being taken.
// Reset: clears both configuration registers to zero and returns to hunting.
module sync_type_xor_frame_receiver
    import stxfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] link_byte
    input  logic        s_axis_tuser,   // [0] command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] payload_byte, [13:8] byte_index
    output logic [1:0]  m_axis_tuser,   // [1:0] status
    output logic        m_axis_tlast
);

    cmd_t              cmd;
    sts_t              sts;
    status_t           out_status;
    logic [BYTE_W-1:0] out_byte;
    logic [POS_W-1:0]  out_index;

    stxfr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_kind  (s_axis_tuser),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    stxfr_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .link_byte  (s_axis_tdata),
        .cmd        (cmd),
        .sts        (sts),
        .out_ready  (m_axis_tready),
        .out_valid  (m_axis_tvalid),
        .out_status (out_status),
        .out_byte   (out_byte),
        .out_index  (out_index),
        .out_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, out_index, out_byte};
    assign m_axis_tuser = out_status;

endmodule
